// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LFCR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfcr assertion failed");

// next-cycle implication
`define LFCR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfcr assertion failed");

`endif

// ===== hw/rtl/lfcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfcr_pkg;

  localparam int HDR_BYTES = 3;
  localparam int CRC_BYTES = 2;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd2;
  localparam logic [15:0] POLY_RESET     = 16'hA001;
  localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;
  localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic             status;
    logic [7:0]       dest_addr;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_len;
    logic             has_payload;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last;
    logic [15:0]      frame_crc;
    logic [15:0]      crc_error_count;
  } item_t;

  // reflected crc, one byte, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lfcr_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lfcr_rx_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lfcr_res_if;
  import lfcr_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [7:0]       dest_addr;
  logic [7:0]       command;
  logic [LEN_W-1:0] payload_len;
  logic             has_payload;
  logic [7:0]       payload_byte;
  logic [IDX_W-1:0] byte_index;
  logic             last;
  logic [15:0]      frame_crc;
  logic [15:0]      crc_error_count;

  modport source (output valid, output status, output dest_addr, output command,
                  output payload_len, output has_payload, output payload_byte,
                  output byte_index, output last, output frame_crc,
                  output crc_error_count, input ready);
  modport sink (input valid, input status, input dest_addr, input command,
                input payload_len, input has_payload, input payload_byte,
                input byte_index, input last, input frame_crc,
                input crc_error_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lfcr_payload_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfcr_payload_ram #(
  parameter int DEPTH = 59,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lfcr_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfcr_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire lfcr_pkg::item_t item,
  output logic                 free,
  lfcr_res_if.source           result
);
  import lfcr_pkg::*;

  logic  valid;
  item_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= item;
    end
  end

  assign free                   = !valid || result.ready;
  assign result.valid           = valid;
  assign result.status          = data.status;
  assign result.dest_addr       = data.dest_addr;
  assign result.command         = data.command;
  assign result.payload_len     = data.payload_len;
  assign result.has_payload     = data.has_payload;
  assign result.payload_byte    = data.payload_byte;
  assign result.byte_index      = data.byte_index;
  assign result.last            = data.last;
  assign result.frame_crc       = data.frame_crc;
  assign result.crc_error_count = data.crc_error_count;

endmodule
`default_nettype wire

// ===== hw/rtl/length_framed_crc_packet_receiver.sv =====
`timescale 1ns / 1ps
// Length-framed packet receiver with CRC-16 check.
// rx channel: one word per received byte (req_type 0) or per millisecond
// tick (req_type 1). A frame is address, command, length L, L payload
// bytes, then the CRC low and high byte (reflected CRC-16, configurable
// polynomial and preset, no final xor).
// result channel: a good frame gives one word per payload byte, or one
// word with has_payload 0 when L is zero; a CRC mismatch gives one error
// word and bumps crc_error_count. last marks the final word of a frame.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 timeout, 1 polynomial,
// 2 CRC preset; written while the block is idle.
// Result path: after the final CRC byte, an empty or failed frame passes
// through S_ONE, which loads its word into the output register; a payload
// frame reads each payload byte from the payload memory in S_RD and loads it
// into the output register in S_LOAD, one byte at a time.
// rx accepts header, payload and tick words back to back while in S_RX and
// is held off in S_ONE, S_RD and S_LOAD; the output register loads only
// when free, so a stalled result channel holds it and rx stays off until
// the frame's last word is loaded into the output register.
// Reset (rst, synchronous): config back to defaults, partial frame and
// error count cleared; the payload memory is not cleared.
`default_nettype none
`include "assert_macros.svh"
module length_framed_crc_packet_receiver #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lfcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  lfcr_rx_if.sink                             rx,
  lfcr_res_if.source                          result
);
  import lfcr_pkg::*;

  localparam int DEPTH = MAX_FRAME_BYTES - HDR_BYTES - CRC_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_FRAME_BYTES + 1);
  localparam int TW    = 9;

  localparam logic [CW-1:0] POS_ADDR = CW'(0);
  localparam logic [CW-1:0] POS_CMD  = CW'(1);
  localparam logic [CW-1:0] POS_LEN  = CW'(2);

  typedef enum logic [3:0] {
    S_RX   = 4'b0001,
    S_ONE  = 4'b0010,
    S_RD   = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  logic [15:0] timeout_ticks;
  logic [15:0] crc_poly;
  logic [15:0] crc_init;

  state_t      state, state_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [CW-1:0] frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] silence_ticks, silence_ticks_next;
  logic        timer_running, timer_running_next;
  logic [7:0]  hdr_addr, hdr_addr_next;
  logic [7:0]  hdr_command, hdr_command_next;
  logic [7:0]  hdr_length, hdr_length_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] frame_crc, frame_crc_next;
  logic [15:0] err_tally, err_tally_next;
  logic        pend_status, pend_status_next;
  logic [AW-1:0] k, k_next;

  logic          rx_acc;
  logic          drop;
  logic [15:0]   crc_base;
  logic [15:0]   limit;
  logic [TW-1:0] total;
  logic [CW:0]   pos_plus_crc;
  logic          k_last;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_rdata;
  logic          out_free;
  logic          out_load;
  item_t         out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      crc_poly      <= POLY_RESET;
      crc_init      <= CRC_INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_ticks <= cfg_data;
        CFG_POLY:     crc_poly      <= cfg_data;
        CFG_CRC_INIT: crc_init      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx.ready     = (state == S_RX);
  assign rx_acc       = rx.valid && rx.ready;
  assign limit        = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign crc_base     = (byte_count == '0) ? crc_init : running_crc;
  assign total        = TW'(HDR_BYTES + CRC_BYTES) + TW'(rx.rx_byte);
  assign pos_plus_crc = (CW+1)'(byte_count) + (CW+1)'(CRC_BYTES);
  assign mem_waddr    = AW'(byte_count - CW'(HDR_BYTES));
  assign k_last       = (9'(k) + 9'd1) == 9'(hdr_length);

  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    running_crc_next   = running_crc;
    silence_ticks_next = silence_ticks;
    timer_running_next = timer_running;
    hdr_addr_next      = hdr_addr;
    hdr_command_next   = hdr_command;
    hdr_length_next    = hdr_length;
    crc_low_byte_next  = crc_low_byte;
    frame_crc_next     = frame_crc;
    err_tally_next     = err_tally;
    pend_status_next   = pend_status;
    k_next             = k;
    drop               = 1'b0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    out_load           = 1'b0;

    out_item.status          = pend_status;
    out_item.dest_addr       = hdr_addr;
    out_item.command         = hdr_command;
    out_item.payload_len     = hdr_length[LEN_W-1:0];
    out_item.has_payload     = 1'b0;
    out_item.payload_byte    = 8'h00;
    out_item.byte_index      = '0;
    out_item.last            = 1'b1;
    out_item.frame_crc       = frame_crc;
    out_item.crc_error_count = err_tally;

    case (state)
      S_RX: begin
        if (rx_acc && rx.req_type == REQ_TICK) begin
          if (timer_running) begin
            if (silence_ticks != SILENCE_MAX) begin
              silence_ticks_next = silence_ticks + 16'd1;
            end
            if (silence_ticks_next >= limit) begin
              drop = 1'b1;
            end
          end
        end else if (rx_acc) begin
          running_crc_next   = crc_base;
          timer_running_next = 1'b1;
          silence_ticks_next = '0;
          if (byte_count >= CW'(MAX_FRAME_BYTES)) begin
            drop = 1'b1;
          end else begin
            byte_count_next = byte_count + CW'(1);
            if (byte_count < CW'(HDR_BYTES)) begin
              if (byte_count == POS_ADDR) begin
                hdr_addr_next = rx.rx_byte;
              end else if (byte_count == POS_CMD) begin
                hdr_command_next = rx.rx_byte;
              end else begin
                hdr_length_next = rx.rx_byte;
              end
              running_crc_next = crc_step(crc_base, rx.rx_byte, crc_poly);
              if (byte_count == POS_LEN) begin
                if (total > TW'(MAX_FRAME_BYTES)) begin
                  drop = 1'b1;
                end else begin
                  frame_length_next = CW'(total);
                end
              end
            end else if (frame_length == '0) begin
              drop = 1'b1;
            end else if (pos_plus_crc < (CW+1)'(frame_length)) begin
              mem_we           = 1'b1;
              running_crc_next = crc_step(crc_base, rx.rx_byte, crc_poly);
            end else if (pos_plus_crc == (CW+1)'(frame_length)) begin
              crc_low_byte_next = rx.rx_byte;
            end else begin
              drop           = 1'b1;
              frame_crc_next = {rx.rx_byte, crc_low_byte};
              k_next         = '0;
              if (frame_crc_next != running_crc) begin
                err_tally_next   = err_tally + 16'd1;
                pend_status_next = STATUS_BAD;
                state_next       = S_ONE;
              end else if (hdr_length == 8'd0) begin
                pend_status_next = STATUS_GOOD;
                state_next       = S_ONE;
              end else begin
                pend_status_next = STATUS_GOOD;
                state_next       = S_RD;
              end
            end
          end
        end
        if (drop) begin
          byte_count_next    = '0;
          frame_length_next  = '0;
          timer_running_next = 1'b0;
          silence_ticks_next = '0;
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_RX;
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        out_item.has_payload  = 1'b1;
        out_item.payload_byte = mem_rdata;
        out_item.byte_index   = IDX_W'(k);
        out_item.last         = k_last;
        if (out_free) begin
          out_load = 1'b1;
          if (k_last) begin
            state_next = S_RX;
          end else begin
            k_next     = k + AW'(1);
            state_next = S_RD;
          end
        end
      end
      default: begin
        state_next = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RX;
      byte_count    <= '0;
      frame_length  <= '0;
      running_crc   <= CRC_INIT_RESET;
      silence_ticks <= '0;
      timer_running <= 1'b0;
      hdr_addr      <= '0;
      hdr_command   <= '0;
      hdr_length    <= '0;
      crc_low_byte  <= '0;
      err_tally     <= '0;
      pend_status   <= STATUS_GOOD;
      k             <= '0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      frame_length  <= frame_length_next;
      running_crc   <= running_crc_next;
      silence_ticks <= silence_ticks_next;
      timer_running <= timer_running_next;
      hdr_addr      <= hdr_addr_next;
      hdr_command   <= hdr_command_next;
      hdr_length    <= hdr_length_next;
      crc_low_byte  <= crc_low_byte_next;
      err_tally     <= err_tally_next;
      pend_status   <= pend_status_next;
      k             <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_crc <= frame_crc_next;
  end

  lfcr_payload_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (rx.rx_byte),
    .re    (mem_re),
    .raddr (k),
    .rdata (mem_rdata)
  );

  lfcr_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .item   (out_item),
    .free   (out_free),
    .result (result)
  );

  `LFCR_ASSERT_IMP(a_count_bound, 1'b1, byte_count <= CW'(MAX_FRAME_BYTES))
  `LFCR_ASSERT_NXT(a_last_word, (state == S_LOAD) && out_free && k_last,
                   (state == S_RX) && result.valid && result.last)
  `LFCR_ASSERT_IMP(a_tally_bad, !$past(rst) && (err_tally != $past(err_tally)),
                   (state == S_ONE) && (pend_status == STATUS_BAD))

endmodule
`default_nettype wire
